### sv/ipc_pkg.sv
`default_nettype none

package ipc_pkg;

    // register indexes on the configuration port
    localparam logic [0:0] REG_ACCEL_SCALE   = 1'd0;
    localparam logic [0:0] REG_CALIB_SAMPLES = 1'd1;

    localparam logic [15:0] ACCEL_SCALE_RST   = 16'd642;
    localparam logic [6:0]  CALIB_SAMPLES_RST = 7'd100;

    // 1.0 squared in Q60
    localparam logic [63:0] ONE_Q60 = 64'h1000_0000_0000_0000;

    // quotient bits produced by the bias divider
    localparam int DIV_STEPS = 41;

    typedef struct packed {
        logic               read_ok;
        logic [2:0]         parts_present;
        logic signed [31:0] quat_in_x;
        logic signed [31:0] quat_in_y;
        logic signed [31:0] quat_in_z;
        logic signed [15:0] raw_accel_x;
        logic signed [15:0] raw_accel_y;
        logic signed [15:0] raw_accel_z;
        logic signed [31:0] field_in_x;
        logic signed [31:0] field_in_y;
        logic signed [31:0] field_in_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] quat_x;
        logic signed [31:0] quat_y;
        logic signed [31:0] quat_z;
        logic [30:0]        quat_w;
        logic signed [31:0] accel_x;
        logic signed [31:0] accel_y;
        logic signed [31:0] accel_z;
        logic signed [31:0] field_x;
        logic signed [31:0] field_y;
        logic signed [31:0] field_z;
    } t_out_item;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_START,
        ST_SQ_MUL,
        ST_SQ_ACC,
        ST_SQRT_GO,
        ST_SQRT_WAIT,
        ST_AC_MUL,
        ST_AC_ACC,
        ST_CALIB,
        ST_DV_LOAD,
        ST_DV_RUN,
        ST_DV_STORE,
        ST_EMIT
    } t_state;

endpackage

`default_nettype wire

### sv/ipc_isqrt.sv
`default_nettype none

module ipc_isqrt (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [60:0] i_radicand,
    output logic             o_done,
    output logic [30:0]      o_root
);

    // one result bit per cycle
    logic        r_busy;
    logic        r_done;
    logic [60:0] r_rem;
    logic [61:0] r_res;
    logic [60:0] r_bit;

    logic [61:0] trial;
    logic        take;

    assign trial = r_res + {1'b0, r_bit};
    assign take  = ({1'b0, r_rem} >= trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_bit[0]) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_radicand;
            r_res <= '0;
            r_bit <= {1'b1, 60'd0};
        end else if (r_busy) begin
            if (take) begin
                r_rem <= r_rem - trial[60:0];
                r_res <= (r_res >> 1) + {1'b0, r_bit};
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_done = r_done;
    assign o_root = r_res[30:0];

endmodule

`default_nettype wire

### sv/imu_packet_convert_with_bias_calib_core.sv
`default_nettype none

// Motion packet converter with acceleration bias calibration. One packet is
// a transaction on the input channel; a packet with read_ok low is taken and
// dropped at once. A good packet updates the held quaternion (scalar part
// rebuilt as floor(sqrt(1 - x^2 - y^2 - z^2)) in Q30, zero at norm one or
// more), the held accelerations (raw * accel_scale - bias, saturated, Q16)
// and the held field, as its parts_present mask says. After reset the first
// calib_samples good packets emit nothing: their accelerations are summed,
// averaged into the bias (rounded, ties away from zero), and the held values
// cleared. Every later good packet emits the whole held set. The
// acceleration part takes three passes through the shared 32x32 multiplier,
// the quaternion part three squares on the same multiplier plus a bit-serial
// square root, and the result is then handed over. The packet that closes
// calibration also runs the bit-serial bias divider once per axis. The
// input stalls while a packet is in work; a result waits in an output
// register so the next packet can start.
module imu_packet_convert_with_bias_calib_core (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [0:0]        i_cfg_index,
    input  wire logic [15:0]       i_cfg_data,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire ipc_pkg::t_in_item i_in_data,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output ipc_pkg::t_out_item     o_out_data
);

    import ipc_pkg::*;

    t_state r_state;
    t_state n_state;

    // configuration
    logic [15:0] r_scale;
    logic [6:0]  r_samples;

    // latched packet
    t_in_item r_in;

    // held set and calibration state
    logic signed [31:0] r_quat [3];
    logic [30:0]        r_quat_w;
    logic signed [31:0] r_accel [3];
    logic signed [31:0] r_field [3];
    logic signed [39:0] r_sum [3];
    logic signed [31:0] r_bias [3];
    logic [6:0]         r_calib_count;

    // sequencer datapath
    logic [1:0]  r_idx;
    logic [63:0] r_prod;
    logic [63:0] r_sq_sum;
    logic [40:0] r_div_num;
    logic [6:0]  r_div_rem;
    logic [5:0]  r_div_cnt;

    // output register
    t_out_item r_out;
    logic      r_out_valid;

    logic signed [31:0] in_quat [3];
    logic signed [15:0] in_raw [3];

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] q_bits;
    logic [15:0] raw_bits;
    logic [31:0] raw_mag;

    logic signed [41:0] ac_prod;
    logic signed [41:0] ac_val;

    logic [39:0] sum_bits;
    logic [39:0] sum_mag;
    logic [7:0]  div_trial;
    logic        div_ge;
    logic signed [41:0] div_q;
    logic signed [41:0] div_val;

    logic        sqrt_start;
    logic [60:0] sqrt_radicand;
    logic        sqrt_done;
    logic [30:0] sqrt_root;

    logic   out_load;
    logic   calib_on;
    t_state after_accel;
    t_state after_quat;

    function automatic logic signed [31:0] sat32(input logic signed [41:0] v);
        logic signed [31:0] r;
        if (v > 42'sd2147483647) begin
            r = 32'sh7fff_ffff;
        end else if (v < -42'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    assign in_quat[0] = r_in.quat_in_x;
    assign in_quat[1] = r_in.quat_in_y;
    assign in_quat[2] = r_in.quat_in_z;
    assign in_raw[0]  = r_in.raw_accel_x;
    assign in_raw[1]  = r_in.raw_accel_y;
    assign in_raw[2]  = r_in.raw_accel_z;

    // shared multiplier operands: magnitudes, sign applied afterwards
    assign q_bits   = in_quat[r_idx];
    assign raw_bits = in_raw[r_idx];
    assign raw_mag  = raw_bits[15] ? (~{16'hffff, raw_bits} + 32'd1) : {16'd0, raw_bits};

    always_comb begin
        if (r_state == ST_AC_MUL) begin
            mul_a = raw_mag;
            mul_b = {16'd0, r_scale};
        end else begin
            mul_a = q_bits[31] ? (~q_bits + 32'd1) : q_bits;
            mul_b = mul_a;
        end
    end

    // acceleration: signed product minus bias
    always_comb begin
        ac_prod = $signed({9'd0, r_prod[32:0]});
        if (raw_bits[15]) begin
            ac_prod = -ac_prod;
        end
        ac_val = ac_prod - 42'(r_bias[r_idx]);
    end

    // bias divider: one quotient bit per cycle
    assign sum_bits  = r_sum[r_idx];
    assign sum_mag   = sum_bits[39] ? (~sum_bits + 40'd1) : sum_bits;
    assign div_trial = {r_div_rem, r_div_num[40]};
    assign div_ge    = (div_trial >= {1'b0, r_calib_count});

    always_comb begin
        div_q   = $signed({1'b0, r_div_num});
        div_val = sum_bits[39] ? -div_q : div_q;
    end

    assign calib_on    = (r_calib_count != 7'd0);
    assign after_accel = calib_on ? ST_CALIB : ST_EMIT;
    assign after_quat  = r_in.parts_present[1] ? ST_AC_MUL : after_accel;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && i_in_data.read_ok) begin
                    n_state = ST_START;
                end
            end
            ST_START: begin
                n_state = r_in.parts_present[0] ? ST_SQ_MUL : after_quat;
            end
            ST_SQ_MUL:   n_state = ST_SQ_ACC;
            ST_SQ_ACC:   n_state = (r_idx == 2'd2) ? ST_SQRT_GO : ST_SQ_MUL;
            ST_SQRT_GO:  n_state = (r_sq_sum >= ONE_Q60) ? after_quat : ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
                if (sqrt_done) begin
                    n_state = after_quat;
                end
            end
            ST_AC_MUL:   n_state = ST_AC_ACC;
            ST_AC_ACC:   n_state = (r_idx == 2'd2) ? after_accel : ST_AC_MUL;
            ST_CALIB:    n_state = (r_calib_count < r_samples) ? ST_IDLE : ST_DV_LOAD;
            ST_DV_LOAD:  n_state = ST_DV_RUN;
            ST_DV_RUN: begin
                if (r_div_cnt == 6'(DIV_STEPS - 1)) begin
                    n_state = ST_DV_STORE;
                end
            end
            ST_DV_STORE: n_state = (r_idx == 2'd2) ? ST_IDLE : ST_DV_LOAD;
            ST_EMIT: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default:     n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_in_stall    = (r_state != ST_IDLE);
        sqrt_start    = (r_state == ST_SQRT_GO) && (r_sq_sum < ONE_Q60);
        sqrt_radicand = 61'(ONE_Q60 - r_sq_sum);
        out_load      = (r_state == ST_EMIT) && (!r_out_valid || !i_out_stall);
    end

    ipc_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (sqrt_radicand),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    // control and model state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_scale       <= ACCEL_SCALE_RST;
            r_samples     <= CALIB_SAMPLES_RST;
            r_calib_count <= 7'd1;
            r_out_valid   <= 1'b0;
            r_idx         <= 2'd0;
            r_quat_w      <= '0;
            for (int k = 0; k < 3; k++) begin
                r_quat[k]  <= '0;
                r_accel[k] <= '0;
                r_field[k] <= '0;
                r_sum[k]   <= '0;
                r_bias[k]  <= '0;
            end
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_ACCEL_SCALE:   r_scale   <= i_cfg_data;
                    REG_CALIB_SAMPLES: r_samples <= i_cfg_data[6:0];
                    default: ;
                endcase
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                ST_START: begin
                    r_idx <= 2'd0;
                    if (r_in.parts_present[0]) begin
                        for (int k = 0; k < 3; k++) begin
                            r_quat[k] <= in_quat[k];
                        end
                    end
                    if (r_in.parts_present[2]) begin
                        r_field[0] <= r_in.field_in_x;
                        r_field[1] <= r_in.field_in_y;
                        r_field[2] <= r_in.field_in_z;
                    end
                end
                ST_SQ_ACC: begin
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                ST_SQRT_GO: begin
                    if (r_sq_sum >= ONE_Q60) begin
                        r_quat_w <= '0;
                    end
                end
                ST_SQRT_WAIT: begin
                    if (sqrt_done) begin
                        r_quat_w <= sqrt_root;
                    end
                end
                ST_AC_ACC: begin
                    r_accel[r_idx] <= sat32(ac_val);
                    r_idx <= (r_idx == 2'd2) ? 2'd0 : r_idx + 2'd1;
                end
                ST_CALIB: begin
                    for (int k = 0; k < 3; k++) begin
                        r_sum[k] <= r_sum[k] + 40'(r_accel[k]);
                    end
                    r_idx <= 2'd0;
                    if (r_calib_count < r_samples) begin
                        r_calib_count <= r_calib_count + 7'd1;
                    end
                end
                ST_DV_STORE: begin
                    r_bias[r_idx] <= sat32(div_val);
                    if (r_idx == 2'd2) begin
                        // calibration over: clear the held set
                        r_idx         <= 2'd0;
                        r_calib_count <= 7'd0;
                        r_quat_w      <= '0;
                        for (int k = 0; k < 3; k++) begin
                            r_quat[k]  <= '0;
                            r_accel[k] <= '0;
                            r_field[k] <= '0;
                        end
                    end else begin
                        r_idx <= r_idx + 2'd1;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_in <= i_in_data;
        end

        if (r_state == ST_START) begin
            r_sq_sum <= '0;
        end else if (r_state == ST_SQ_ACC) begin
            r_sq_sum <= r_sq_sum + r_prod;
        end

        // the one shared multiplier, registered
        if (r_state == ST_SQ_MUL || r_state == ST_AC_MUL) begin
            r_prod <= mul_a * mul_b;
        end

        if (r_state == ST_DV_LOAD) begin
            r_div_num <= {1'b0, sum_mag} + {35'd0, r_calib_count[6:1]};
            r_div_rem <= '0;
            r_div_cnt <= '0;
        end else if (r_state == ST_DV_RUN) begin
            r_div_rem <= div_ge ? 7'(div_trial - {1'b0, r_calib_count}) : div_trial[6:0];
            r_div_num <= {r_div_num[39:0], div_ge};
            r_div_cnt <= r_div_cnt + 6'd1;
        end

        if (out_load) begin
            r_out.quat_x  <= r_quat[0];
            r_out.quat_y  <= r_quat[1];
            r_out.quat_z  <= r_quat[2];
            r_out.quat_w  <= r_quat_w;
            r_out.accel_x <= r_accel[0];
            r_out.accel_y <= r_accel[1];
            r_out.accel_z <= r_accel[2];
            r_out.field_x <= r_field[0];
            r_out.field_y <= r_field[1];
            r_out.field_z <= r_field[2];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire
